[rtl/core/lpvd_pkg.sv]
// ----------------------------------------------------------------------------
// lpvd_pkg
// Types, widths and codes shared by the Lp vector distance block.
// ----------------------------------------------------------------------------
package lpvd_pkg;

    localparam int DATA_WIDTH = 12;             // element bits taken, two's complement
    localparam int ELEM_W     = 12;             // port width of an element
    localparam int DIFF_W     = DATA_WIDTH;     // |a - b| fits in DATA_WIDTH unsigned bits
    localparam int ACC_W      = 58;
    localparam int DIST_W     = 22;
    localparam int PROD_W     = 60;             // every power and trial power is below 2^60
    localparam int MUL_A_W    = 40;
    localparam int MUL_B_W    = 30;
    localparam int ROOT_W     = 30;
    localparam int BIT_W      = 5;
    localparam int CFG_W      = 3;

    localparam logic [BIT_W-1:0] ROOT_TOP_L2 = BIT_W'(29);
    localparam logic [BIT_W-1:0] ROOT_TOP_L3 = BIT_W'(19);
    localparam logic [BIT_W-1:0] ROOT_TOP_L4 = BIT_W'(14);

    localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [CFG_W-1:0] {
        METRIC_L1   = 3'd0,
        METRIC_L2   = 3'd1,
        METRIC_L3   = 3'd2,
        METRIC_L4   = 3'd3,
        METRIC_LINF = 3'd4
    } t_metric;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DD,     // d * d
        MUL_PD,     // product * d
        MUL_PP,     // product * product
        MUL_CC,     // candidate * candidate
        MUL_PC      // product * candidate
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD_D,
        ACC_ADD_P,
        ACC_MAX_D
    } t_acc_op;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     has_element;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } t_out_item;

    typedef struct packed {
        logic     load_diff;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     root_init;
        logic     root_step;
        logic     out_load;
        t_metric  metric;
    } t_dp_cmd;

    typedef struct packed {
        logic root_last;
    } t_dp_sts;

    // Unused selector codes act as L-infinity
    function automatic t_metric metric_decode(input logic [CFG_W-1:0] sel);
        t_metric m;
        unique case (sel) inside
            METRIC_L1, METRIC_L2, METRIC_L3, METRIC_L4: m = t_metric'(sel);
            default:                                    m = METRIC_LINF;
        endcase
        return m;
    endfunction

    function automatic logic [BIT_W-1:0] root_top(input t_metric m);
        logic [BIT_W-1:0] t;
        unique case (m)
            METRIC_L2: t = ROOT_TOP_L2;
            METRIC_L3: t = ROOT_TOP_L3;
            default:   t = ROOT_TOP_L4;
        endcase
        return t;
    endfunction

endpackage

[rtl/core/lpvd_dp.sv]
// ----------------------------------------------------------------------------
// lpvd_dp
// Datapath: absolute difference, shared multiplier, saturating accumulator,
// bit-serial root and the result register.
// ----------------------------------------------------------------------------
module lpvd_dp import lpvd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_item o_out_item
);

    logic [DIFF_W-1:0]  r_d;
    logic [PROD_W-1:0]  r_pw;
    logic [ACC_W-1:0]   r_acc;
    logic               r_ovf;
    logic [ROOT_W-1:0]  r_root;
    logic [BIT_W-1:0]   r_bit;
    t_out_item          r_out;

    logic [DATA_WIDTH-1:0]       w_a;
    logic [DATA_WIDTH-1:0]       w_b;
    logic [DATA_WIDTH:0]         w_diff;
    logic [DATA_WIDTH:0]         w_abs;
    logic [ROOT_W-1:0]           w_cand;
    logic [MUL_A_W-1:0]          w_mul_a;
    logic [MUL_B_W-1:0]          w_mul_b;
    logic [MUL_A_W+MUL_B_W-1:0]  w_prod;
    logic [PROD_W-1:0]           w_addend;
    logic [PROD_W:0]             w_sum;
    logic [ACC_W-1:0]            w_dist_full;
    logic                        w_lin;

    assign w_a    = i_in_item.elem_a[DATA_WIDTH-1:0];
    assign w_b    = i_in_item.elem_b[DATA_WIDTH-1:0];
    assign w_diff = {w_a[DATA_WIDTH-1], w_a} - {w_b[DATA_WIDTH-1], w_b};
    assign w_abs  = w_diff[DATA_WIDTH] ? (~w_diff + 1'b1) : w_diff;

    assign w_cand = r_root | (ROOT_W'(1) << r_bit);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DD: begin
                w_mul_a = MUL_A_W'(r_d);
                w_mul_b = MUL_B_W'(r_d);
            end
            MUL_PD: begin
                w_mul_a = r_pw[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(r_d);
            end
            MUL_PP: begin
                w_mul_a = r_pw[MUL_A_W-1:0];
                w_mul_b = r_pw[MUL_B_W-1:0];
            end
            MUL_CC: begin
                w_mul_a = MUL_A_W'(w_cand);
                w_mul_b = MUL_B_W'(w_cand);
            end
            MUL_PC: begin
                w_mul_a = r_pw[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(w_cand);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod   = w_mul_a * w_mul_b;
    assign w_addend = (i_cmd.acc_op == ACC_ADD_D) ? PROD_W'(r_d) : r_pw;
    assign w_sum    = (PROD_W+1)'(r_acc) + (PROD_W+1)'(w_addend);

    assign w_lin       = (i_cmd.metric == METRIC_L1) || (i_cmd.metric == METRIC_LINF);
    assign w_dist_full = w_lin ? r_acc : ACC_W'(r_root);

    // Accumulator and overflow flag carry reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else begin
            case (i_cmd.acc_op)
                ACC_ADD_D, ACC_ADD_P: begin
                    if (w_sum > (PROD_W+1)'(ACC_MAX)) begin
                        r_acc <= ACC_MAX;
                        r_ovf <= 1'b1;
                    end else begin
                        r_acc <= w_sum[ACC_W-1:0];
                    end
                end
                ACC_MAX_D: begin
                    if (ACC_W'(r_d) > r_acc) begin
                        r_acc <= ACC_W'(r_d);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_diff) begin
            r_d <= w_abs[DIFF_W-1:0];
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_pw <= w_prod[PROD_W-1:0];
        end
        if (i_cmd.root_init) begin
            r_root <= '0;
            r_bit  <= root_top(i_cmd.metric);
        end else if (i_cmd.root_step) begin
            // keep the trial bit when its power stays within the sum
            if (r_pw <= PROD_W'(r_acc)) begin
                r_root <= w_cand;
            end
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.out_load) begin
            if (w_dist_full > ACC_W'(DIST_MAX)) begin
                r_out.distance  <= DIST_MAX;
                r_out.saturated <= 1'b1;
            end else begin
                r_out.distance  <= w_dist_full[DIST_W-1:0];
                r_out.saturated <= r_ovf;
            end
        end
    end

    assign o_sts.root_last = (r_bit == '0);
    assign o_out_item      = r_out;

endmodule

[rtl/core/lpvd_ctrl.sv]
// ----------------------------------------------------------------------------
// lpvd_ctrl
// Controller: metric register, per-item sequencing and result handshake.
// ----------------------------------------------------------------------------
module lpvd_ctrl import lpvd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_dp_cmd          o_cmd,
    input  t_dp_sts          i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_FIN,
        S_RMUL1,
        S_RMUL2,
        S_RCMP,
        S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_metric_sel;
    t_metric          r_cur, n_cur;
    logic             r_last;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_lin;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_lin    = (r_cur == METRIC_L1) || (r_cur == METRIC_LINF);

    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_sel   = MUL_NONE;
        o_cmd.acc_op    = ACC_HOLD;
        o_cmd.metric    = r_cur;
        n_state         = r_state;
        n_cur           = r_cur;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_diff = 1'b1;
                    n_cur           = metric_decode(r_metric_sel);
                    if (!i_in_item.has_element) begin
                        n_state = S_FIN;
                    end else if ((n_cur == METRIC_L1) || (n_cur == METRIC_LINF)) begin
                        n_state = S_ACC;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul_sel = MUL_DD;
                n_state       = (r_cur == METRIC_L2) ? S_ACC : S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_sel = (r_cur == METRIC_L3) ? MUL_PD : MUL_PP;
                n_state       = S_ACC;
            end
            S_ACC: begin
                if (r_cur == METRIC_L1) begin
                    o_cmd.acc_op = ACC_ADD_D;
                end else if (r_cur == METRIC_LINF) begin
                    o_cmd.acc_op = ACC_MAX_D;
                end else begin
                    o_cmd.acc_op = ACC_ADD_P;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (w_lin) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.root_init = 1'b1;
                    n_state         = S_RMUL1;
                end
            end
            S_RMUL1: begin
                o_cmd.mul_sel = MUL_CC;
                n_state       = (r_cur == METRIC_L2) ? S_RCMP : S_RMUL2;
            end
            S_RMUL2: begin
                o_cmd.mul_sel = (r_cur == METRIC_L3) ? MUL_PC : MUL_PP;
                n_state       = S_RCMP;
            end
            S_RCMP: begin
                o_cmd.root_step = 1'b1;
                n_state         = i_sts.root_last ? S_OUT : S_RMUL1;
            end
            S_OUT: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_metric_sel <= '0;
            r_cur        <= METRIC_L1;
            r_last       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            if (i_cfg_we) begin
                r_metric_sel <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_last <= i_in_item.last;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/lp_vector_distance.sv]
// ----------------------------------------------------------------------------
// lp_vector_distance
// Streamed L1, L2, L3, L4 or L-infinity distance between two vectors.
// ----------------------------------------------------------------------------
// One transaction carries one element pair; the transaction marked last
// yields the distance, and the accumulator then starts over. Items are
// handled one at a time by a controller that steps a single shared
// multiplier. On the last item the floor root is found one result bit
// at a time with the same multiplier: 30 bits for L2, 20 for L3 and 15
// for L4. The result sits in an output register, so the next vector may
// start while it waits to be taken. metric_select is sampled when an
// item is accepted; the user must see that it is written only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lp_vector_distance import lpvd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lpvd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lpvd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_item (o_out_item)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is still in progress");

    a_result_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("result load did not raise output valid");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");
`endif

endmodule
